// ----- sv/gdfw_pkg.sv -----
`default_nettype none
package gdfw_pkg;

    localparam int VERTEX_W         = 4;
    localparam int REQ_W            = 2;
    localparam int STATUS_W         = 2;
    localparam int NODE_COUNT_W     = 5;
    localparam int NODE_COUNT_RESET = 9;
    localparam int RESULT_CAP       = 16;
    localparam int CNT_W            = $clog2(RESULT_CAP + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_WALK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                valid;
        logic [VERTEX_W-1:0] vertex;
        logic                last;
        logic [STATUS_W-1:0] status;
    } post_t;

endpackage
`default_nettype wire

// ----- sv/gdfw_ram.sv -----
`default_nettype none
module gdfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/gdfw_engine.sv -----
`default_nettype none
module gdfw_engine #(
    parameter int MAX_NODES = 16,
    parameter int MAX_EDGES = 64
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [gdfw_pkg::REQ_W-1:0]           req_type,
    input  wire logic [gdfw_pkg::VERTEX_W-1:0]        vertex_a,
    input  wire logic [gdfw_pkg::VERTEX_W-1:0]        vertex_b,
    input  wire logic                                 is_directed,
    input  wire logic [gdfw_pkg::NODE_COUNT_W-1:0]    node_count,
    input  wire logic                                 out_free,
    output gdfw_pkg::post_t                           post
);
    import gdfw_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int EAW   = $clog2(MAX_EDGES);
    localparam int EW    = $clog2(MAX_EDGES + 1);
    localparam int DW    = $clog2(MAX_NODES + 1);
    localparam int LIM_W = (DW > NODE_COUNT_W) ? DW : NODE_COUNT_W;
    localparam int FW    = VERTEX_W + EW;
    localparam logic [EW-1:0] NULL_LINK = EW'(MAX_EDGES);

    typedef enum logic [8:0] {
        IDLE      = 9'b000000001,
        ADD_RD    = 9'b000000010,
        ADD_WR    = 9'b000000100,
        RESP      = 9'b000001000,
        WALK_HEAD = 9'b000010000,
        WALK_STEP = 9'b000100000,
        WALK_POP  = 9'b001000000,
        WALK_EDGE = 9'b010000000,
        FINISH    = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    status_t               status_reg, status_next;
    logic [VERTEX_W-1:0]   src_reg, src_next;
    logic [VERTEX_W-1:0]   dst_reg, dst_next;
    logic                  dir_reg, dir_next;
    logic                  second_reg, second_next;
    logic [EW-1:0]         edges_used_reg, edges_used_next;
    logic [MAX_NODES-1:0]  head_valid_reg, head_valid_next;
    logic [MAX_NODES-1:0]  visited_reg, visited_next;
    logic [VERTEX_W-1:0]   top_v_reg, top_v_next;
    logic [EW-1:0]         top_pos_reg, top_pos_next;
    logic [DW-1:0]         depth_reg, depth_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VERTEX_W-1:0]   pend_reg, pend_next;

    logic [LIM_W-1:0]      lim;
    logic                  accept;
    logic                  a_ok, b_ok, room_ok;
    logic [EW:0]           need_sum;

    logic [VERTEX_W-1:0]   head_rv;
    logic [EW-1:0]         head_rdata;
    logic                  head_we;
    logic [EW-1:0]         src_link;

    logic                  edge_we, edge_re;
    logic [FW-1:0]         edge_rdata;
    logic [VERTEX_W-1:0]   edge_t;
    logic [EW-1:0]         edge_link;
    logic                  fresh;

    logic                  stk_we, stk_re;
    logic [NW-1:0]         stk_waddr, stk_raddr;
    logic [FW-1:0]         stk_rdata;

    assign lim = (LIM_W'(node_count) < LIM_W'(MAX_NODES)) ? LIM_W'(node_count)
                                                           : LIM_W'(MAX_NODES);
    assign s_ready  = (state_reg == IDLE);
    assign accept   = s_valid && s_ready;
    assign a_ok     = LIM_W'(vertex_a) < lim;
    assign b_ok     = LIM_W'(vertex_b) < lim;
    assign need_sum = {1'b0, edges_used_reg} + (is_directed ? (EW + 1)'(1) : (EW + 1)'(2));
    assign room_ok  = need_sum <= (EW + 1)'(MAX_EDGES);

    assign edge_t    = edge_rdata[EW +: VERTEX_W];
    assign edge_link = edge_rdata[EW-1:0];
    assign fresh     = (LIM_W'(edge_t) < lim) && !visited_reg[NW'(edge_t)];
    assign src_link  = head_valid_reg[NW'(src_reg)] ? head_rdata : NULL_LINK;

    always_comb begin
        case (state_reg)
            IDLE:    head_rv = vertex_a;
            ADD_RD:  head_rv = src_reg;
            default: head_rv = edge_t;
        endcase
    end

    assign head_we   = (state_reg == ADD_WR);
    assign edge_we   = (state_reg == ADD_WR);
    assign edge_re   = (state_reg == WALK_STEP) && (top_pos_reg != NULL_LINK);
    assign stk_re    = (state_reg == WALK_STEP) && (top_pos_reg == NULL_LINK);
    assign stk_raddr = NW'(depth_reg - DW'(2));
    assign stk_waddr = NW'(depth_reg - DW'(1));

    gdfw_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_head (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (NW'(src_reg)),
        .wdata (edges_used_reg),
        .re    (1'b1),
        .raddr (NW'(head_rv)),
        .rdata (head_rdata)
    );

    gdfw_ram #(.WIDTH(FW), .DEPTH(MAX_EDGES)) u_edge (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (edges_used_reg[EAW-1:0]),
        .wdata ({dst_reg, src_link}),
        .re    (edge_re),
        .raddr (top_pos_reg[EAW-1:0]),
        .rdata (edge_rdata)
    );

    gdfw_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata ({top_v_reg, edge_link}),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        status_next     = status_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        dir_next        = dir_reg;
        second_next     = second_reg;
        edges_used_next = edges_used_reg;
        head_valid_next = head_valid_reg;
        visited_next    = visited_reg;
        top_v_next      = top_v_reg;
        top_pos_next    = top_pos_reg;
        depth_next      = depth_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        stk_we          = 1'b0;
        post            = '0;

        unique case (state_reg)
            IDLE: begin
                if (accept) begin
                    case (req_type)
                        REQ_CLEAR: begin
                            head_valid_next = '0;
                            edges_used_next = '0;
                            status_next     = ST_OK;
                            state_next      = RESP;
                        end
                        REQ_ADD: begin
                            if (!a_ok || !b_ok) begin
                                status_next = ST_RANGE;
                                state_next  = RESP;
                            end else if (!room_ok) begin
                                status_next = ST_FULL;
                                state_next  = RESP;
                            end else begin
                                src_next    = vertex_a;
                                dst_next    = vertex_b;
                                dir_next    = is_directed;
                                second_next = 1'b0;
                                state_next  = ADD_WR;
                            end
                        end
                        REQ_WALK: begin
                            if (!a_ok) begin
                                status_next = ST_RANGE;
                                state_next  = RESP;
                            end else begin
                                visited_next               = '0;
                                visited_next[NW'(vertex_a)] = 1'b1;
                                pend_next                  = vertex_a;
                                cnt_next                   = CNT_W'(1);
                                top_v_next                 = vertex_a;
                                depth_next                 = DW'(1);
                                state_next                 = WALK_HEAD;
                            end
                        end
                        default: begin
                            state_next = IDLE;
                        end
                    endcase
                end
            end
            ADD_RD: begin
                state_next = ADD_WR;
            end
            ADD_WR: begin
                head_valid_next[NW'(src_reg)] = 1'b1;
                edges_used_next               = edges_used_reg + EW'(1);
                if (!dir_reg && !second_reg) begin
                    second_next = 1'b1;
                    src_next    = dst_reg;
                    dst_next    = src_reg;
                    state_next  = ADD_RD;
                end else begin
                    status_next = ST_OK;
                    state_next  = RESP;
                end
            end
            RESP: begin
                if (out_free) begin
                    post.valid  = 1'b1;
                    post.last   = 1'b1;
                    post.status = status_reg;
                    state_next  = IDLE;
                end
            end
            WALK_HEAD: begin
                top_pos_next = head_valid_reg[NW'(top_v_reg)] ? head_rdata : NULL_LINK;
                state_next   = WALK_STEP;
            end
            WALK_STEP: begin
                if (top_pos_reg != NULL_LINK) begin
                    state_next = WALK_EDGE;
                end else if (depth_reg == DW'(1)) begin
                    state_next = FINISH;
                end else begin
                    state_next = WALK_POP;
                end
            end
            WALK_POP: begin
                top_v_next   = stk_rdata[EW +: VERTEX_W];
                top_pos_next = stk_rdata[EW-1:0];
                depth_next   = depth_reg - DW'(1);
                state_next   = WALK_STEP;
            end
            WALK_EDGE: begin
                if (!fresh) begin
                    top_pos_next = edge_link;
                    state_next   = WALK_STEP;
                end else if (out_free) begin
                    post.valid                = 1'b1;
                    post.vertex               = pend_reg;
                    pend_next                 = edge_t;
                    visited_next[NW'(edge_t)] = 1'b1;
                    cnt_next                  = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(RESULT_CAP - 1)) begin
                        state_next = FINISH;
                    end else begin
                        stk_we     = 1'b1;
                        top_v_next = edge_t;
                        depth_next = depth_reg + DW'(1);
                        state_next = WALK_HEAD;
                    end
                end
            end
            FINISH: begin
                if (out_free) begin
                    post.valid  = 1'b1;
                    post.vertex = pend_reg;
                    post.last   = 1'b1;
                    depth_next  = '0;
                    state_next  = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= IDLE;
            edges_used_reg <= '0;
            head_valid_reg <= '0;
            visited_reg    <= '0;
            depth_reg      <= '0;
            cnt_reg        <= '0;
            second_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            edges_used_reg <= edges_used_next;
            head_valid_reg <= head_valid_next;
            visited_reg    <= visited_next;
            depth_reg      <= depth_next;
            cnt_reg        <= cnt_next;
            second_reg     <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        dir_reg     <= dir_next;
        top_v_reg   <= top_v_next;
        top_pos_reg <= top_pos_next;
        pend_reg    <= pend_next;
    end

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(MAX_NODES))
        else $error("walk stack overflow");

    a_post_free: assert property (@(posedge aclk) disable iff (!aresetn)
        post.valid |-> out_free)
        else $error("result posted into a busy output register");

    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && req_type == REQ_WALK && a_ok) |=> $onehot(visited_reg))
        else $error("visited marks not reset to the start vertex");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(RESULT_CAP))
        else $error("result count past cap");

    a_walk_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == WALK_HEAD || state_reg == WALK_STEP || state_reg == WALK_POP
         || state_reg == WALK_EDGE) |-> depth_reg != '0)
        else $error("walk running on an empty stack");

endmodule
`default_nettype wire

// ----- sv/graph_depth_first_walk_top.sv -----
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_req_type s_vertex_a s_vertex_b s_is_directed
// m_        out        m_valid / m_ready    m_vertex m_last m_status
// apb       in         psel penable pready  paddr pwrite pwdata prdata
//
// Clear and rejected requests post one status result. Unknown request: no result.
// Add edge: writes one list entry when directed, two when undirected.
// Walk: reads each vertex's list head, examines its edges one by one, descends into each
// fresh vertex it reaches and pops the stack when a list runs out, then posts the last
// vertex; one item at a time.
// Reset is synchronous; list heads carry valid bits, so no clearing pass is needed.
// A walk holds while the output register is full; new requests wait in IDLE.
`default_nettype none
module graph_depth_first_walk_top #(
    parameter int MAX_NODES = 16,
    parameter int MAX_EDGES = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [gdfw_pkg::REQ_W-1:0]          s_req_type,
    input  wire logic [gdfw_pkg::VERTEX_W-1:0]       s_vertex_a,
    input  wire logic [gdfw_pkg::VERTEX_W-1:0]       s_vertex_b,
    input  wire logic                                s_is_directed,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [gdfw_pkg::VERTEX_W-1:0]       m_vertex,
    output logic                                     m_last,
    output logic      [gdfw_pkg::STATUS_W-1:0]       m_status,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready
);
    import gdfw_pkg::*;

    logic [NODE_COUNT_W-1:0] node_count_reg;
    logic                    reg_sel;
    logic                    cfg_write;

    logic                    m_valid_reg;
    logic [VERTEX_W-1:0]     m_vertex_reg;
    logic                    m_last_reg;
    logic [STATUS_W-1:0]     m_status_reg;
    logic                    out_free;
    post_t                   post;

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == 1'b0);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign prdata    = reg_sel ? 32'(node_count_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_W'(NODE_COUNT_RESET);
        end else if (cfg_write) begin
            node_count_reg <= pwdata[NODE_COUNT_W-1:0];
        end
    end

    gdfw_engine #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .req_type    (s_req_type),
        .vertex_a    (s_vertex_a),
        .vertex_b    (s_vertex_b),
        .is_directed (s_is_directed),
        .node_count  (node_count_reg),
        .out_free    (out_free),
        .post        (post)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (post.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (post.valid) begin
            m_vertex_reg <= post.vertex;
            m_last_reg   <= post.last;
            m_status_reg <= post.status;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_vertex = m_vertex_reg;
    assign m_last   = m_last_reg;
    assign m_status = m_status_reg;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;
    import gdfw_pkg::*;

    localparam int NODE_SLOTS       = 16;
    localparam int EDGE_SLOTS       = 64;
    localparam int NULL_LINK        = EDGE_SLOTS;
    localparam int RANDOM_ITEMS     = 240;
    localparam int LONG_HOLD        = 400;
    localparam int SETTLE_CYCLES    = 12;
    localparam int TIMEOUT_CYCLES   = 2_000_000;
    localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

    typedef enum {PH_MIXED, PH_CHAIN, PH_FILL, PH_PROBE} phase_t;

    typedef struct {
        logic [VERTEX_W-1:0] vertex;
        logic                last;
        status_t             status;
    } visit_t;

    class dfs_scoreboard;
        bit [NODE_COUNT_W-1:0] node_count;
        bit [6:0]              list_head   [NODE_SLOTS];
        bit [VERTEX_W-1:0]     edge_target [EDGE_SLOTS];
        bit [6:0]              edge_link   [EDGE_SLOTS];
        bit                    visited     [NODE_SLOTS];
        bit [6:0]              frame_pos   [NODE_SLOTS];
        int                    edges_used;
        visit_t                pending_visits[$];
        int mismatches;
        int results_checked;
        int requests_noted;
        int walk_visits;
        int range_rejects;
        int full_rejects;

        function new();
            node_count = NODE_COUNT_RESET;
            empty_lists();
        endfunction

        function void empty_lists();
            foreach (list_head[i]) list_head[i] = NULL_LINK;
            edges_used = 0;
        endfunction

        function int vertex_limit();
            return (node_count < NODE_SLOTS) ? int'(node_count) : NODE_SLOTS;
        endfunction

        function void link_edge(int from, int to);
            edge_target[edges_used] = to;
            edge_link[edges_used]   = list_head[from];
            list_head[from]         = edges_used;
            edges_used++;
        endfunction

        function void expect_status(status_t st);
            visit_t v;
            v.vertex = '0;
            v.last   = 1'b1;
            v.status = st;
            pending_visits.push_back(v);
            if (st == ST_RANGE) range_rejects++;
            if (st == ST_FULL) full_rejects++;
        endfunction

        function void expect_visit(int vtx);
            visit_t v;
            v.vertex = vtx;
            v.last   = 1'b0;
            v.status = ST_OK;
            pending_visits.push_back(v);
            walk_visits++;
        endfunction

        function void note_request(req_t req, int a, int b, bit directed);
            int lim;
            int depth;
            int emitted;
            int e;
            int t;
            lim = vertex_limit();
            requests_noted++;
            case (req)
                REQ_CLEAR: begin
                    empty_lists();
                    expect_status(ST_OK);
                end
                REQ_ADD: begin
                    if (a >= lim || b >= lim) begin
                        expect_status(ST_RANGE);
                    end else if (edges_used + (directed ? 1 : 2) > EDGE_SLOTS) begin
                        expect_status(ST_FULL);
                    end else begin
                        link_edge(a, b);
                        if (!directed) link_edge(b, a);
                        expect_status(ST_OK);
                    end
                end
                REQ_WALK: begin
                    if (a >= lim) begin
                        expect_status(ST_RANGE);
                    end else begin
                        foreach (visited[i]) visited[i] = 1'b0;
                        visited[a] = 1'b1;
                        expect_visit(a);
                        emitted      = 1;
                        frame_pos[0] = list_head[a];
                        depth        = 1;
                        while (depth > 0 && emitted < RESULT_CAP) begin
                            e = frame_pos[depth-1];
                            if (e >= EDGE_SLOTS) begin
                                depth--;
                            end else begin
                                t = edge_target[e];
                                frame_pos[depth-1] = edge_link[e];
                                if (t < lim && !visited[t] && depth < NODE_SLOTS) begin
                                    visited[t] = 1'b1;
                                    expect_visit(t);
                                    emitted++;
                                    frame_pos[depth] = list_head[t];
                                    depth++;
                                end
                            end
                        end
                        pending_visits[pending_visits.size()-1].last = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            $display("ERROR result %0d %s: got %0d, want %0d", results_checked, what, got, want);
        endtask

        task check_result(logic [VERTEX_W-1:0] vertex, logic last, logic [STATUS_W-1:0] status);
            visit_t want;
            if (pending_visits.size() == 0) begin
                report_mismatch("result with nothing pending, vertex", vertex, -1);
                return;
            end
            want = pending_visits.pop_front();
            results_checked++;
            if (vertex !== want.vertex) report_mismatch("vertex", vertex, want.vertex);
            if (last !== want.last) report_mismatch("last", last, want.last);
            if (status !== want.status) report_mismatch("status", status, want.status);
        endtask
    endclass

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type    = '0;
    logic [VERTEX_W-1:0] s_vertex_a    = '0;
    logic [VERTEX_W-1:0] s_vertex_b    = '0;
    logic                s_is_directed = 1'b0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [VERTEX_W-1:0] m_vertex;
    logic                m_last;
    logic [STATUS_W-1:0] m_status;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [2:0]          paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;

    dfs_scoreboard sb;
    bit            quiet;
    int            items_sent;
    int            config_writes;

    graph_depth_first_walk_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_vertex_a    (s_vertex_a),
        .s_vertex_b    (s_vertex_b),
        .s_is_directed (s_is_directed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vertex      (m_vertex),
        .m_last        (m_last),
        .m_status      (m_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [VERTEX_W-1:0] pick_vertex();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, sb.vertex_limit() - 1);
        return $urandom_range(0, 15);
    endfunction

    function automatic int pick_node_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 1;
        if (r < 45) return NODE_SLOTS;
        return $urandom_range(2, 15);
    endfunction

    task automatic send_request(req_t req, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b,
                                logic directed);
        int gap;
        s_valid       = 1'b1;
        s_req_type    = req;
        s_vertex_a    = a;
        s_vertex_b    = b;
        s_is_directed = directed;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req, a, b, directed);
        if (req != REQ_NONE) items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
        gap = pick_gap();
        if (gap > 0) begin
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic check_node_count_reg();
        psel    = 1'b1;
        pwrite  = 1'b0;
        paddr   = ADDR_NODE_COUNT;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(sb.node_count))
            sb.report_mismatch("node_count readback", prdata, sb.node_count);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_node_count(int value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = ADDR_NODE_COUNT;
        pwdata  = value;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.node_count = value;
        config_writes++;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_node_count_reg();
    endtask

    task automatic wait_drained();
        while (sb.pending_visits.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            send_request(REQ_ADD, pick_vertex(), pick_vertex(), $urandom_range(0, 1));
        else if (r < 90)
            send_request(REQ_WALK, pick_vertex(), $urandom_range(0, 15), $urandom_range(0, 1));
        else if (r < 94)
            send_request(REQ_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 1));
        else
            send_request(REQ_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 1));
    endtask

    task automatic run_phase(int phase_no);
        phase_t kind;
        int     perm [NODE_SLOTS];
        int     j;
        int     tmp;
        int     k;
        int     r;
        wait_drained();
        quiet = ($urandom_range(0, 4) == 0);
        if (phase_no == 0) kind = PH_CHAIN;
        else if (phase_no == 1) kind = PH_FILL;
        else if (phase_no == 2) kind = PH_MIXED;
        else begin
            r = $urandom_range(0, 9);
            kind = (r < 5) ? PH_MIXED : (r < 7) ? PH_CHAIN : (r < 9) ? PH_FILL : PH_PROBE;
        end
        case (kind)
            PH_MIXED: begin
                set_node_count((phase_no == 2) ? 1 : pick_node_count());
                if ($urandom_range(0, 2) == 0) send_request(REQ_CLEAR, 0, 0, 0);
                repeat ($urandom_range(6, 20)) random_request();
            end
            PH_CHAIN: begin
                // a path through every vertex drives the walk to the result cap
                set_node_count(NODE_SLOTS);
                send_request(REQ_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15), 1'b0);
                foreach (perm[i]) perm[i] = i;
                for (int i = NODE_SLOTS - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                for (int i = 0; i < NODE_SLOTS - 1; i++)
                    send_request(REQ_ADD, perm[i], perm[i+1], $urandom_range(0, 1));
                send_request(REQ_WALK, perm[0], $urandom_range(0, 15), $urandom_range(0, 1));
                send_request(REQ_WALK, $urandom_range(0, 15), 0, 0);
                // shrink the vertex range so stored edges go stale
                wait_drained();
                set_node_count($urandom_range(1, 12));
                send_request(REQ_WALK, pick_vertex(), 0, 1);
                send_request(REQ_WALK, 0, $urandom_range(0, 15), 0);
                send_request(REQ_WALK, pick_vertex(), 0, 0);
            end
            PH_FILL: begin
                set_node_count($urandom_range(4, NODE_SLOTS));
                k = 0;
                while (sb.edges_used < EDGE_SLOTS && k < 40) begin
                    send_request(REQ_ADD, $urandom_range(0, sb.vertex_limit() - 1),
                                 $urandom_range(0, sb.vertex_limit() - 1),
                                 $urandom_range(0, 3) == 0);
                    k++;
                end
                repeat (4)
                    send_request(REQ_ADD, $urandom_range(0, sb.vertex_limit() - 1),
                                 $urandom_range(0, sb.vertex_limit() - 1), $urandom_range(0, 1));
                repeat (3) send_request(REQ_WALK, pick_vertex(), 0, 0);
            end
            default: begin
                set_node_count(pick_node_count());
                repeat ($urandom_range(5, 12)) begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        send_request(REQ_WALK, $urandom_range(0, 15), $urandom_range(0, 15),
                                     $urandom_range(0, 1));
                    else if (r < 80)
                        send_request(REQ_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                                     $urandom_range(0, 1));
                    else
                        send_request(REQ_ADD, $urandom_range(0, 15), $urandom_range(0, 15),
                                     $urandom_range(0, 1));
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_vertex, m_last, m_status);
    end

    initial begin
        int  stall_left;
        bit  held_long;
        stall_left = 0;
        held_long  = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!held_long && sb.results_checked >= 100 && s_valid) begin
                // hold off long enough for the block to back up onto its input
                held_long = 1'b1;
                m_ready   = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_ready   = 1'b1;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("graph_depth_first_walk_top: mismatch");
        $finish;
    end

    initial begin
        int phase_no;
        int target;
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        check_node_count_reg();

        // reset vertex range, empty graph, range rejects at the limit and beyond
        send_request(REQ_WALK, 0, 15, 1);
        send_request(REQ_WALK, 9, 0, 0);
        send_request(REQ_WALK, 15, 15, 1);
        send_request(REQ_ADD, 0, 15, 1);
        send_request(REQ_ADD, 15, 0, 0);
        send_request(REQ_ADD, 9, 3, 1);
        send_request(REQ_ADD, 0, 1, 0);
        send_request(REQ_ADD, 1, 2, 1);
        send_request(REQ_ADD, 2, 2, 0);
        send_request(REQ_ADD, 0, 8, 1);
        send_request(REQ_ADD, 8, 3, 0);
        send_request(REQ_NONE, 15, 15, 1);
        send_request(REQ_WALK, 0, 0, 0);
        send_request(REQ_WALK, 2, 5, 1);
        send_request(REQ_WALK, 8, 0, 0);
        send_request(REQ_CLEAR, 15, 15, 1);
        send_request(REQ_WALK, 1, 0, 0);
        send_request(REQ_ADD, 3, 4, 1);
        send_request(REQ_WALK, 3, 0, 0);

        target   = items_sent + RANDOM_ITEMS;
        phase_no = 0;
        while (items_sent < target) begin
            run_phase(phase_no);
            phase_no++;
        end
        wait_drained();

        $display("Run covered %0d requests in %0d phases with %0d node_count writes.",
                 sb.requests_noted, phase_no, config_writes);
        $display("Checked %0d results: %0d walk vertices, %0d range and %0d store-full rejects.",
                 sb.results_checked, sb.walk_visits, sb.range_rejects, sb.full_rejects);
        if (sb.mismatches == 0) begin
            $display("graph_depth_first_walk_top: match");
        end else begin
            $display("graph_depth_first_walk_top: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
